/* sv/irss_pkg.sv */
// Shared types, constants and table lookups for the infrared range sweep scanner.
// No dependencies; imported by ir_range_sweep_scanner.
package irss_pkg;

	localparam int STEP_DEG_DEF    = 5;
	localparam int MAX_SAMPLES_DEF = 32;

	// distance table size and tick period
	localparam int TBL_N   = 14;
	localparam int TICK_MS = 20;

	// divider geometry
	localparam int DIV_NW = 26;
	localparam int DIV_DW = 19;
	localparam int DIV_CW = 5;

	localparam logic [25:0] BEEP_NUM = 26'd40000000;

	// sequencer states
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SRCH = 6'b000010,
		S_DIVC = 6'b000100,
		S_UPD  = 6'b001000,
		S_DIVB = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	// table voltage in hundredths of a volt
	function automatic int tbl_v(input logic [3:0] i);
		int r;
		unique case (i)
			4'd0:    r = 250;
			4'd1:    r = 200;
			4'd2:    r = 155;
			4'd3:    r = 125;
			4'd4:    r = 110;
			4'd5:    r = 85;
			4'd6:    r = 80;
			4'd7:    r = 73;
			4'd8:    r = 70;
			4'd9:    r = 65;
			4'd10:   r = 60;
			4'd11:   r = 50;
			4'd12:   r = 45;
			4'd13:   r = 40;
			default: r = 40;
		endcase
		return r;
	endfunction

	// table voltage scaled by the full-scale code
	function automatic logic [20:0] tbl_v4095(input logic [3:0] i);
		return 21'(tbl_v(i) * 4095);
	endfunction

	// twice the segment span below entry i, scaled by the full-scale code
	function automatic logic [18:0] seg_den2(input logic [3:0] i);
		return 19'(2 * (tbl_v(i - 4'd1) - tbl_v(i)) * 4095);
	endfunction

	// 2*cm*den + den for entry i (rounding offset included)
	function automatic logic [25:0] seg_base(input logic [3:0] i);
		int cm;
		int den;
		cm  = 20 + 10 * int'(i);
		den = (tbl_v(i - 4'd1) - tbl_v(i)) * 4095;
		return 26'(2 * cm * den + den);
	endfunction

	function automatic logic [6:0] half_of(input logic [1:0] m);
		logic [6:0] r;
		unique case (m)
			2'd0: r = 7'd60;
			2'd1: r = 7'd30;
			2'd2: r = 7'd20;
			2'd3: r = 7'd15;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] delay_of(input logic [1:0] m);
		logic [5:0] r;
		unique case (m)
			2'd0: r = 6'd40;
			2'd1: r = 6'd38;
			2'd2: r = 6'd37;
			2'd3: r = 6'd36;
		endcase
		return r;
	endfunction

	// servo pulse for a signed angle, clamped to 700..2300
	function automatic logic [11:0] pulse_of(input logic signed [7:0] a);
		logic signed [13:0] ax;
		logic signed [13:0] p;
		ax = 14'(a);
		p  = 14'sd1500 + (ax <<< 3) + (ax <<< 1) + ax;
		if (p < 14'sd700)
			p = 14'sd700;
		if (p > 14'sd2300)
			p = 14'sd2300;
		return p[11:0];
	endfunction

endpackage

/* sv/ir_range_sweep_scanner.sv */
// Infrared range sweep scanner: tick sequencer, table search and shared divider.
// Depends on irss_pkg.
//
//  channel | handshake          | beat contents
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | adc_sample, switch_code
//  out     | out_valid/out_ready| servo_pulse, sample_*, sweep_*, front_cm,
//          |                    | buzzer_period_us, alert
//
// A first or waiting tick goes straight to output. A measuring tick walks the table,
// runs the 26-step restoring divider unless the sample clamps, updates and outputs;
// a sweep end with a front minimum of 20..100 cm reruns it for the beep period.
// in_ready is high only while the sequencer is idle; a finished beat waits in the
// output register while the next tick is taken. arst_n clears all control state.
module ir_range_sweep_scanner #(
	parameter int STEP_DEG    = irss_pkg::STEP_DEG_DEF,
	parameter int MAX_SAMPLES = irss_pkg::MAX_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] adc_sample,
	input  logic [1:0]  switch_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] servo_pulse,
	output logic        sample_valid,
	output logic signed [6:0] sample_angle,
	output logic [7:0]  sample_cm,
	output logic [4:0]  sample_index,
	output logic        sweep_done,
	output logic [5:0]  sweep_count,
	output logic        sweep_reverse,
	output logic [7:0]  front_cm,
	output logic [20:0] buzzer_period_us,
	output logic        alert
);
	import irss_pkg::*;

	// samples per sweep for each mode
	localparam int NR0 = (2 * 60) / STEP_DEG + 1;
	localparam int NR1 = (2 * 30) / STEP_DEG + 1;
	localparam int NR2 = (2 * 20) / STEP_DEG + 1;
	localparam int NR3 = (2 * 15) / STEP_DEG + 1;
	localparam logic [5:0] N0 = 6'((NR0 > MAX_SAMPLES) ? MAX_SAMPLES : NR0);
	localparam logic [5:0] N1 = 6'((NR1 > MAX_SAMPLES) ? MAX_SAMPLES : NR1);
	localparam logic [5:0] N2 = 6'((NR2 > MAX_SAMPLES) ? MAX_SAMPLES : NR2);
	localparam logic [5:0] N3 = 6'((NR3 > MAX_SAMPLES) ? MAX_SAMPLES : NR3);
	localparam logic signed [7:0] STEP_A = 8'(STEP_DEG);

	state_t state_q;

	// scanner state
	logic              started_q;
	logic              fwd_q;
	logic [5:0]        step_q;
	logic signed [7:0] angle_q;
	logic [7:0]        fmin_q;
	logic [5:0]        tacc_q;
	logic [1:0]        mode_q;
	logic [20:0]       beep_q;

	// per-tick working registers
	logic [20:0] v_q;
	logic [1:0]  sw_q;
	logic [3:0]  idx_q;
	logic [7:0]  cm_q;

	// staged result fields
	logic              st_sv_q;
	logic signed [6:0] st_ang_q;
	logic [7:0]        st_cm_q;
	logic [4:0]        st_idx_q;
	logic              st_sd_q;
	logic [5:0]        st_cnt_q;
	logic              st_rev_q;
	logic [7:0]        st_front_q;
	logic              st_alert_q;

	// shared restoring divider
	logic [DIV_NW-1:0] dnum_q;
	logic [DIV_DW-1:0] dden_q;
	logic [DIV_DW-1:0] drem_q;
	logic [DIV_NW-1:0] dquo_q;
	logic [DIV_CW-1:0] dcnt_q;
	logic [DIV_DW:0]   drem_sh;
	logic              dge;
	logic [DIV_DW:0]   drem_sub;
	logic [DIV_DW-1:0] drem_nx;
	logic [DIV_NW-1:0] dquo_nx;

	logic        in_acc;
	logic        out_free;
	logic [5:0]  tacc_add;
	logic [5:0]  dly;
	logic [5:0]  n_cur;
	logic [20:0] x_seg;
	logic [25:0] cm_num;
	logic [7:0]  fmin_new;
	logic [5:0]  step_nx;
	logic [6:0]  beep_d;
	logic [6:0]  half_sw;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	assign tacc_add = tacc_q + 6'(TICK_MS);
	assign dly      = delay_of(mode_q);
	assign half_sw  = half_of(sw_q);

	always_comb begin
		unique case (mode_q)
			2'd0: n_cur = N0;
			2'd1: n_cur = N1;
			2'd2: n_cur = N2;
			2'd3: n_cur = N3;
		endcase
	end

	// one divider step: shift in the next dividend bit, subtract when it fits
	assign drem_sh  = {drem_q, dnum_q[DIV_NW-1]};
	assign dge      = (drem_sh >= {1'b0, dden_q});
	assign drem_sub = drem_sh - {1'b0, dden_q};
	assign drem_nx  = dge ? drem_sub[DIV_DW-1:0] : drem_sh[DIV_DW-1:0];
	assign dquo_nx  = {dquo_q[DIV_NW-2:0], dge};

	// numerator of the interpolation for the current segment
	assign x_seg  = v_q - tbl_v4095(idx_q);
	assign cm_num = seg_base(idx_q) - ((26'(x_seg) << 4) + (26'(x_seg) << 2));

	// frontal minimum and sweep progress for the measured sample
	assign fmin_new = (angle_q >= -8'sd10 && angle_q <= 8'sd10 && cm_q < fmin_q)
		? cm_q : fmin_q;
	assign step_nx  = step_q + 6'd1;
	assign beep_d   = 7'd120 - fmin_new[6:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			fwd_q     <= 1'b1;
			step_q    <= '0;
			angle_q   <= '0;
			fmin_q    <= 8'd150;
			tacc_q    <= '0;
			mode_q    <= '0;
			beep_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!started_q) begin
							started_q <= 1'b1;
							mode_q    <= switch_code;
							angle_q   <= fwd_q ? -8'(half_of(switch_code))
								: 8'(half_of(switch_code));
							state_q   <= S_FIN;
						end else if (tacc_add < dly) begin
							tacc_q  <= tacc_add;
							state_q <= S_FIN;
						end else begin
							tacc_q  <= tacc_add - dly;
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					// clamp ends first, then walk the table for the segment
					if (idx_q == 4'd0 && v_q >= tbl_v4095(4'd0)) begin
						state_q <= S_UPD;
					end else if (idx_q == 4'd0 && v_q <= tbl_v4095(4'(TBL_N - 1))) begin
						state_q <= S_UPD;
					end else if (idx_q != 4'd0 && v_q >= tbl_v4095(idx_q)) begin
						state_q <= S_DIVC;
					end
				end
				S_DIVC: begin
					if (dcnt_q == '0)
						state_q <= S_UPD;
				end
				S_UPD: begin
					if (step_nx >= n_cur) begin
						fwd_q   <= !fwd_q;
						step_q  <= '0;
						fmin_q  <= 8'd150;
						mode_q  <= sw_q;
						angle_q <= fwd_q ? 8'(half_sw) : -8'(half_sw);
						if (fmin_new >= 8'd20 && fmin_new <= 8'd100) begin
							state_q <= S_DIVB;
						end else begin
							beep_q  <= '0;
							state_q <= S_FIN;
						end
					end else begin
						fmin_q  <= fmin_new;
						step_q  <= step_nx;
						angle_q <= fwd_q ? angle_q + STEP_A : angle_q - STEP_A;
						state_q <= S_FIN;
					end
				end
				S_DIVB: begin
					if (dcnt_q == '0) begin
						beep_q  <= dquo_nx[20:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers, staged fields and divider datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q        <= 21'(adc_sample * 10'd330);
			sw_q       <= switch_code;
			idx_q      <= '0;
			st_sv_q    <= 1'b0;
			st_ang_q   <= '0;
			st_cm_q    <= '0;
			st_idx_q   <= '0;
			st_sd_q    <= 1'b0;
			st_cnt_q   <= '0;
			st_rev_q   <= 1'b0;
			st_front_q <= '0;
			st_alert_q <= 1'b0;
		end
		// table walk and divider load
		if (state_q == S_SRCH) begin
			if (idx_q == 4'd0 && v_q >= tbl_v4095(4'd0)) begin
				cm_q <= 8'd20;
			end else if (idx_q == 4'd0 && v_q <= tbl_v4095(4'(TBL_N - 1))) begin
				cm_q <= 8'd150;
			end else if (idx_q != 4'd0 && v_q >= tbl_v4095(idx_q)) begin
				dnum_q <= cm_num;
				dden_q <= seg_den2(idx_q);
				drem_q <= '0;
				dquo_q <= '0;
				dcnt_q <= DIV_CW'(DIV_NW - 1);
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
		// advance the divider
		if (state_q == S_DIVC || state_q == S_DIVB) begin
			drem_q <= drem_nx;
			dquo_q <= dquo_nx;
			dnum_q <= dnum_q << 1;
			dcnt_q <= dcnt_q - 1'b1;
			if (state_q == S_DIVC && dcnt_q == '0)
				cm_q <= dquo_nx[7:0];
		end
		// stage the sample and sweep fields
		if (state_q == S_UPD) begin
			st_sv_q  <= 1'b1;
			st_ang_q <= angle_q[6:0];
			st_cm_q  <= cm_q;
			st_idx_q <= step_q[4:0];
			if (step_nx >= n_cur) begin
				st_sd_q    <= 1'b1;
				st_cnt_q   <= step_nx;
				st_rev_q   <= !fwd_q;
				st_front_q <= fmin_new;
				st_alert_q <= (fmin_new < 8'd30);
				dnum_q     <= BEEP_NUM + 26'(beep_d >> 1);
				dden_q     <= DIV_DW'(beep_d);
				drem_q     <= '0;
				dquo_q     <= '0;
				dcnt_q     <= DIV_CW'(DIV_NW - 1);
			end
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			servo_pulse      <= pulse_of(angle_q);
			sample_valid     <= st_sv_q;
			sample_angle     <= st_ang_q;
			sample_cm        <= st_cm_q;
			sample_index     <= st_idx_q;
			sweep_done       <= st_sd_q;
			sweep_count      <= st_cnt_q;
			sweep_reverse    <= st_rev_q;
			front_cm         <= st_front_q;
			buzzer_period_us <= beep_q;
			alert            <= st_alert_q;
		end
	end

endmodule

/* tb/tb_top.sv */
// Testbench for ir_range_sweep_scanner: directed and random ticks, checked beat by beat
// against an in-bench prediction of the sweep sequencer. Depends on irss_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int STEP = irss_pkg::STEP_DEG_DEF;
	localparam int NMAX = irss_pkg::MAX_SAMPLES_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [11:0] pulse;
		logic        s_valid;
		logic [6:0]  s_angle;
		logic [7:0]  s_cm;
		logic [4:0]  s_index;
		logic        done;
		logic [5:0]  count;
		logic        rev;
		logic [7:0]  front;
		logic [20:0] beep;
		logic        alert;
	} scan_beat_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [11:0] adc_sample;
	logic [1:0]  switch_code;
	logic [11:0] servo_pulse;
	logic        sample_valid, sweep_done, sweep_reverse, alert;
	logic signed [6:0] sample_angle;
	logic [7:0]  sample_cm, front_cm;
	logic [4:0]  sample_index;
	logic [5:0]  sweep_count;
	logic [20:0] buzzer_period_us;

	ir_range_sweep_scanner u_top (.*);

	// predictor state
	bit     p_started;
	bit     p_fwd;
	int     p_step;
	int     p_angle;
	int     p_front;
	int     p_acc;
	int     p_mode;
	longint p_beep;

	scan_beat_t expected_beats[$];
	int  errors, beats_seen, sweeps_seen, items_sent, idle_cycles;
	bit  hold_off;
	int  hold_len;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int half_deg(int m);
		case (m)
			0: return 60;
			1: return 30;
			2: return 20;
			default: return 15;
		endcase
	endfunction

	function automatic int step_delay(int m);
		case (m)
			0: return 40;
			1: return 38;
			2: return 37;
			default: return 36;
		endcase
	endfunction

	function automatic int servo_us(int a);
		int p;
		p = 1500 + 11 * a;
		if (p < 700) p = 700;
		if (p > 2300) p = 2300;
		return p;
	endfunction

	function automatic int adc_cm(int adc);
		int tv[14] = '{250, 200, 155, 125, 110, 85, 80, 73, 70, 65, 60, 50, 45, 40};
		longint v, lo, den, a, num;
		v = longint'(adc) * 330;
		if (v >= 250 * 4095) return 20;
		if (v <= 40 * 4095) return 150;
		for (int i = 1; i < 14; i++) begin
			lo = longint'(tv[i]) * 4095;
			if (v >= lo) begin
				den = longint'(tv[i-1] - tv[i]) * 4095;
				a = (v - lo) * 10;
				num = 2 * longint'(20 + 10 * i) * den + den - 2 * a;
				return int'(num / (2 * den));
			end
		end
		return 150;
	endfunction

	function automatic longint beep_us(int cm);
		longint d;
		if (cm < 20 || cm > 100) return 0;
		d = 120 - cm;
		return (40000000 + d / 2) / d;
	endfunction

	// predict the beat caused by one tick
	function automatic scan_beat_t predict_tick(int adc, int sw);
		scan_beat_t b;
		int n, cm;
		b = '0;
		if (!p_started) begin
			p_started = 1;
			p_mode = sw;
			p_angle = p_fwd ? -half_deg(p_mode) : half_deg(p_mode);
		end else begin
			n = 2 * half_deg(p_mode) / STEP + 1;
			if (n > NMAX) n = NMAX;
			p_acc += 20;
			if (p_acc >= step_delay(p_mode)) begin
				p_acc -= step_delay(p_mode);
				cm = adc_cm(adc);
				if (p_angle >= -10 && p_angle <= 10 && cm < p_front) p_front = cm;
				b.s_valid = 1;
				b.s_angle = 7'(p_angle);
				b.s_cm = 8'(cm);
				b.s_index = 5'(p_step);
				p_step++;
				if (p_step >= n) begin
					p_beep = beep_us(p_front);
					b.done = 1;
					b.count = 6'(p_step);
					b.rev = !p_fwd;
					b.front = 8'(p_front);
					b.alert = p_front < 30;
					p_fwd = !p_fwd;
					p_step = 0;
					p_front = 150;
					p_mode = sw;
					p_angle = p_fwd ? -half_deg(p_mode) : half_deg(p_mode);
				end else begin
					p_angle += p_fwd ? STEP : -STEP;
				end
			end
		end
		b.pulse = 12'(servo_us(p_angle));
		b.beep = 21'(p_beep);
		return b;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// offer one tick and wait until it is taken; valid drops only before a gap
	task automatic send_tick(input int adc, input int sw, input bit gaps = 1);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid    <= 1;
		adc_sample  <= 12'(adc);
		switch_code <= 2'(sw);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_beats.push_back(predict_tick(adc, sw));
		items_sent++;
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 0;
			hold_len <= 0;
		end else if (hold_off) begin
			out_ready <= 0;
		end else if (hold_len > 0) begin
			hold_len <= hold_len - 1;
			out_ready <= 0;
		end else if ($urandom_range(0, 9) == 0) begin
			hold_len <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
				: $urandom_range(1, 3);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		scan_beat_t got, exp_b;
		if (arst_n && out_valid && out_ready) begin
			got = '{servo_pulse, sample_valid, sample_angle, sample_cm, sample_index,
				sweep_done, sweep_count, sweep_reverse, front_cm, buzzer_period_us, alert};
			beats_seen++;
			if (sweep_done) sweeps_seen++;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat %h", $realtime, got);
				errors++;
			end else begin
				exp_b = expected_beats.pop_front();
				if (got !== exp_b) begin
					$display("%0t: mismatch expected %h actual %h", $realtime, exp_b, got);
					if (got.pulse !== exp_b.pulse)
						$display("%0t:  pulse expected %0d actual %0d", $realtime,
							exp_b.pulse, got.pulse);
					if (got.s_cm !== exp_b.s_cm)
						$display("%0t:  cm expected %0d actual %0d", $realtime,
							exp_b.s_cm, got.s_cm);
					if (got.beep !== exp_b.beep)
						$display("%0t:  beep expected %0d actual %0d", $realtime,
							exp_b.beep, got.beep);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// first tick, waiting ticks and conversion extremes
	task automatic test_directed();
		int adcs[12] = '{0, 4095, 3102, 3103, 496, 497, 2500, 1600, 1000, 800, 620, 1241};
		send_tick(4095, 0);
		foreach (adcs[i]) send_tick(adcs[i], i % 4);
		for (int i = 0; i < 10; i++) send_tick(4095 - 12'(1 << i), 0);
	endtask

	// a run of close targets in the frontal window to hit alert and beeping
	task automatic test_close_front();
		for (int i = 0; i < 60; i++) send_tick(($urandom_range(0, 1) ? 4095 : 3000), 3);
	endtask

	// hold the receiver off while ticks keep coming so the block stalls its input
	task automatic test_backpressure();
		hold_off = 1;
		fork
			repeat (400) @(posedge clk);
			for (int i = 0; i < 6; i++) send_tick($urandom_range(0, 4095), $urandom_range(0, 3), 0);
		join_any
		hold_off = 0;
		wait fork;
	endtask

	task automatic test_random();
		int v;
		for (int i = 0; i < 600; i++) begin
			case ($urandom_range(0, 3))
				0: v = $urandom_range(0, 4095);
				1: v = $urandom_range(450, 1300);
				2: v = $urandom_range(2400, 4095);
				default: v = $urandom_range(1300, 2400);
			endcase
			send_tick(v, $urandom_range(0, 3));
		end
	endtask

	initial begin
		int waited;
		in_valid = 0; adc_sample = 0; switch_code = 0;
		hold_off = 0; errors = 0; beats_seen = 0; sweeps_seen = 0;
		items_sent = 0; idle_cycles = 0;
		p_started = 0; p_fwd = 1; p_step = 0; p_angle = 0; p_front = 150;
		p_acc = 0; p_mode = 0; p_beep = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_close_front();
		test_backpressure();
		test_random();
		in_valid <= 0;
		waited = 0;
		while (expected_beats.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		$display("Sent %0d ticks, checked %0d beats, %0d sweep ends.",
			items_sent, beats_seen, sweeps_seen);
		if (errors == 0 && expected_beats.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* ir_range_sweep_scanner.f */
sv/irss_pkg.sv
sv/ir_range_sweep_scanner.sv
tb/tb_top.sv
